[rtl/core/skt_pkg.sv]
`timescale 1ns / 1ps

package skt_pkg;

    // Table geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int CMD_W    = 3;
    localparam int KEY_W    = 32;
    localparam int GRADE_W  = 8;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    localparam int IN_FIELDS_W  = CMD_W + KEY_W + GRADE_W;
    localparam int OUT_FIELDS_W = STATUS_W + GRADE_W + POS_W + COUNT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP         = 3'd0,
        CMD_INSERT         = 3'd1,
        CMD_FIND_OR_INSERT = 3'd2,
        CMD_UPDATE         = 3'd3,
        CMD_DELETE         = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_PRESENT   = 2'd3
    } status_t;

    // Action broadcast to the cell row
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_UPDATE = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef struct packed {
        logic               cmp_en;
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [GRADE_W-1:0] grade;
    } skt_ctrl_t;

    typedef struct packed {
        logic lt;       // occupied and stored key below search key
        logic eq;       // occupied and stored key equals search key
        logic at_slot;  // first cell whose key is not below the search key
    } skt_flags_t;

endpackage

[rtl/core/sorted_key_table.sv]
`timescale 1ns / 1ps
// A command is registered on acceptance; the compare state then registers the cell flags, and the
// apply state shifts the cell row and registers the result item on the output once it is free.
// A new command is taken only while idle or as the previous result is posted, so items do not overlap.
// Reset (rst_n low, asynchronous): entry count cleared, sequencer idle, output empty.
// Entry keys and grades are not cleared; only entries below the count ever reach an output.

module sorted_key_table
(
    input  logic                             clk,
    input  logic                             rst_n,
    // s_axis_tdata fields, low bit up: cmd[2:0], key[34:3], grade[42:35], zero pad
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [skt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // m_axis_tdata fields, low bit up: status[1:0], grade_out[9:2], position[13:10],
    // entry_count[18:14], zero pad
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [skt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int CAP   = skt_pkg::CAPACITY;
    localparam int IDX_W = skt_pkg::IDX_W;
    localparam int CNT_W = skt_pkg::CNT_W;
    localparam int PAD_W = skt_pkg::OUT_TDATA_W - skt_pkg::OUT_FIELDS_W;

    // Sequencer: idle, compare in every cell, then apply and post the result
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Command held for the duration of the item
    logic [skt_pkg::CMD_W-1:0]   cmd_reg;
    logic [skt_pkg::KEY_W-1:0]   key_reg;
    logic [skt_pkg::GRADE_W-1:0] grade_reg;

    logic [CNT_W-1:0]            count_reg, count_sel;

    // Output register
    logic                        out_valid_reg;
    logic [skt_pkg::OUT_FIELDS_W-1:0] out_data_reg;

    logic in_fire, out_free, apply_fire;

    // Cell row
    skt_pkg::skt_ctrl_t          ctrl;
    skt_pkg::skt_flags_t         flags   [CAP];
    logic [skt_pkg::KEY_W-1:0]   c_key   [CAP];
    logic [skt_pkg::GRADE_W-1:0] c_grade [CAP];
    logic [CAP-1:0]              at_slot_vec, lt_vec;

    // Slot result gathered from the row
    logic                        hit;
    logic                        full;
    logic [skt_pkg::GRADE_W-1:0] slot_grade;
    logic [IDX_W-1:0]            slot_pos;

    // Decision
    skt_pkg::op_t                op_sel;
    skt_pkg::status_t            status_sel;
    logic [skt_pkg::GRADE_W-1:0] gout_sel;
    logic [IDX_W-1:0]            pos_sel;

    assign out_free      = ~out_valid_reg | m_axis_tready;
    assign apply_fire    = (state_reg == S_APPLY) && out_free;
    assign s_axis_tready = (state_reg == S_IDLE) || apply_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign ctrl.cmp_en = (state_reg == S_CMP);
    assign ctrl.op     = apply_fire ? op_sel : skt_pkg::OP_NONE;
    assign ctrl.key    = key_reg;
    assign ctrl.grade  = grade_reg;

    // Build the row; each cell sees its neighbors' entries for shifting
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        logic                        lt_prev_w;
        logic [skt_pkg::KEY_W-1:0]   left_key_w, right_key_w;
        logic [skt_pkg::GRADE_W-1:0] left_grade_w, right_grade_w;

        if (i == 0)
        begin : g_first
            assign lt_prev_w    = 1'b1;
            assign left_key_w   = key_reg;
            assign left_grade_w = grade_reg;
        end
        else
        begin : g_mid_l
            assign lt_prev_w    = flags[i-1].lt;
            assign left_key_w   = c_key[i-1];
            assign left_grade_w = c_grade[i-1];
        end

        if (i == CAP - 1)
        begin : g_last
            assign right_key_w   = c_key[i];
            assign right_grade_w = c_grade[i];
        end
        else
        begin : g_mid_r
            assign right_key_w   = c_key[i+1];
            assign right_grade_w = c_grade[i+1];
        end

        skt_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (count_reg > CNT_W'(i)),
            .lt_prev     (lt_prev_w),
            .left_key    (left_key_w),
            .left_grade  (left_grade_w),
            .right_key   (right_key_w),
            .right_grade (right_grade_w),
            .key         (c_key[i]),
            .grade       (c_grade[i]),
            .flags       (flags[i])
        );

        assign at_slot_vec[i] = flags[i].at_slot;
        assign lt_vec[i]      = flags[i].lt;
    end

    // At most one cell marks the slot: read its grade and index by an OR over the row
    always_comb
    begin
        hit        = 1'b0;
        slot_grade = '0;
        slot_pos   = '0;
        for (int i = 0; i < CAP; i++)
        begin
            hit        = hit | (flags[i].at_slot & flags[i].eq);
            slot_grade = slot_grade | (flags[i].at_slot ? c_grade[i] : '0);
            slot_pos   = slot_pos | (flags[i].at_slot ? IDX_W'(i) : '0);
        end
    end

    assign full = (count_reg == CNT_W'(CAP));

    always_comb
    begin
        op_sel     = skt_pkg::OP_NONE;
        status_sel = skt_pkg::ST_OK;
        gout_sel   = '0;
        pos_sel    = '0;
        count_sel  = count_reg;
        unique case (cmd_reg)
            skt_pkg::CMD_LOOKUP:
            begin
                if (hit)
                begin
                    gout_sel = slot_grade;
                    pos_sel  = slot_pos;
                end
                else
                    status_sel = skt_pkg::ST_NOT_FOUND;
            end
            skt_pkg::CMD_INSERT:
            begin
                if (full)
                    status_sel = skt_pkg::ST_FULL;
                else
                begin
                    op_sel    = skt_pkg::OP_INSERT;
                    gout_sel  = grade_reg;
                    pos_sel   = slot_pos;
                    count_sel = CNT_W'(count_reg + 1'b1);
                end
            end
            skt_pkg::CMD_FIND_OR_INSERT:
            begin
                if (hit)
                begin
                    status_sel = skt_pkg::ST_PRESENT;
                    gout_sel   = slot_grade;
                    pos_sel    = slot_pos;
                end
                else if (full)
                    status_sel = skt_pkg::ST_FULL;
                else
                begin
                    op_sel    = skt_pkg::OP_INSERT;
                    gout_sel  = grade_reg;
                    pos_sel   = slot_pos;
                    count_sel = CNT_W'(count_reg + 1'b1);
                end
            end
            skt_pkg::CMD_UPDATE:
            begin
                if (hit)
                begin
                    op_sel   = skt_pkg::OP_UPDATE;
                    gout_sel = grade_reg;
                    pos_sel  = slot_pos;
                end
                else
                    status_sel = skt_pkg::ST_NOT_FOUND;
            end
            skt_pkg::CMD_DELETE:
            begin
                if (hit)
                begin
                    op_sel    = skt_pkg::OP_DELETE;
                    gout_sel  = slot_grade;
                    pos_sel   = slot_pos;
                    count_sel = CNT_W'(count_reg - 1'b1);
                end
                else
                    status_sel = skt_pkg::ST_NOT_FOUND;
            end
            default:
            begin
                // unused command: ok with zeroed grade and position, table untouched
                op_sel = skt_pkg::OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_CMP;
            end
            S_CMP:
                state_next = S_APPLY;
            S_APPLY:
            begin
                // a new item may enter on the same edge that posts this result
                if (in_fire)
                    state_next = S_CMP;
                else if (apply_fire)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (apply_fire)
            begin
                count_reg     <= count_sel;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg   <= s_axis_tdata[skt_pkg::CMD_W-1:0];
            key_reg   <= s_axis_tdata[skt_pkg::CMD_W +: skt_pkg::KEY_W];
            grade_reg <= s_axis_tdata[skt_pkg::CMD_W + skt_pkg::KEY_W +: skt_pkg::GRADE_W];
        end
        if (apply_fire)
            out_data_reg <= {skt_pkg::COUNT_W'(count_sel),
                             skt_pkg::POS_W'(pos_sel),
                             gout_sel,
                             status_sel};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_data_reg};

    // The entry count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAP))
        else $error("entry count above capacity");

    // The slot marker is held by at most one cell
    a_slot_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> $onehot0(at_slot_vec))
        else $error("more than one slot cell");

    // Stored keys are ascending, so below-key flags form a prefix of the row
    a_lt_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> (((lt_vec >> 1) & ~lt_vec) == '0))
        else $error("table order broken");

    // An applied insert grows the table by exactly one entry
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (apply_fire && (op_sel == skt_pkg::OP_INSERT)) |=>
            (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("insert did not advance count");

    // An applied delete shrinks the table by exactly one entry
    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        (apply_fire && (op_sel == skt_pkg::OP_DELETE)) |=>
            (count_reg == CNT_W'($past(count_reg) - 1'b1)))
        else $error("delete did not reduce count");

endmodule

[rtl/core/skt_cell.sv]
`timescale 1ns / 1ps

module skt_cell
(
    input  logic                          clk,
    input  skt_pkg::skt_ctrl_t            ctrl,
    input  logic                          occupied,
    input  logic                          lt_prev,
    input  logic [skt_pkg::KEY_W-1:0]     left_key,
    input  logic [skt_pkg::GRADE_W-1:0]   left_grade,
    input  logic [skt_pkg::KEY_W-1:0]     right_key,
    input  logic [skt_pkg::GRADE_W-1:0]   right_grade,
    output logic [skt_pkg::KEY_W-1:0]     key,
    output logic [skt_pkg::GRADE_W-1:0]   grade,
    output skt_pkg::skt_flags_t           flags
);

    logic [skt_pkg::KEY_W-1:0]   key_reg,   key_next;
    logic [skt_pkg::GRADE_W-1:0] grade_reg, grade_next;
    logic                        lt_reg, eq_reg;
    logic                        at_slot, above_slot;

    assign at_slot    = lt_prev & ~lt_reg;
    assign above_slot = ~lt_prev;

    always_comb
    begin
        key_next   = key_reg;
        grade_next = grade_reg;
        unique case (ctrl.op)
            skt_pkg::OP_INSERT:
            begin
                // open a gap at the slot, move higher entries up
                if (at_slot)
                begin
                    key_next   = ctrl.key;
                    grade_next = ctrl.grade;
                end
                else if (above_slot)
                begin
                    key_next   = left_key;
                    grade_next = left_grade;
                end
            end
            skt_pkg::OP_UPDATE:
            begin
                if (at_slot)
                    grade_next = ctrl.grade;
            end
            skt_pkg::OP_DELETE:
            begin
                // close the gap, move higher entries down
                if (at_slot || above_slot)
                begin
                    key_next   = right_key;
                    grade_next = right_grade;
                end
            end
            default:
            begin
                key_next   = key_reg;
                grade_next = grade_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        grade_reg <= grade_next;
        if (ctrl.cmp_en)
        begin
            lt_reg <= occupied && (key_reg < ctrl.key);
            eq_reg <= occupied && (key_reg == ctrl.key);
        end
    end

    assign key           = key_reg;
    assign grade         = grade_reg;
    assign flags.lt      = lt_reg;
    assign flags.eq      = eq_reg;
    assign flags.at_slot = at_slot;

endmodule
